/* rtl/swrm_pkg.sv */
package swrm_pkg;

    // Field widths
    localparam int BYTES_W    = 32;
    localparam int TIME_W     = 40;
    localparam int SUM_W      = 40;
    localparam int WIN_W      = 16;
    localparam int HELD_W     = 7;

    // sum * 1000 needs 10 more bits than the sum
    localparam int DIVIDEND_W = SUM_W + 10;
    localparam int ITER_W     = $clog2(DIVIDEND_W);

    // Defaults
    localparam int               FIFO_DEPTH_DEF = 64;
    localparam logic [WIN_W-1:0] WINDOW_RESET   = WIN_W'(5000);

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

    // Input operation codes
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_MERGE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_RATE,
        ST_DIV
    } state_t;

    // Entry store control
    typedef struct packed {
        logic rd_en;
        logic wr_bytes;
        logic wr_time;
    } fifo_ctl_t;

endpackage

/* rtl/swrm_fifo.sv */
module swrm_fifo
    import swrm_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int AW         = $clog2(FIFO_DEPTH)
)
(
    input  logic               clk,
    input  fifo_ctl_t          ctl,
    input  logic [AW-1:0]      wr_addr,
    input  logic [AW-1:0]      rd_addr,
    input  logic [BYTES_W-1:0] wr_bytes_data,
    input  logic [TIME_W-1:0]  wr_time_data,
    output logic [BYTES_W-1:0] rd_bytes,
    output logic [TIME_W-1:0]  rd_time
);

    logic [BYTES_W-1:0] bytes_mem [FIFO_DEPTH];
    logic [TIME_W-1:0]  time_mem  [FIFO_DEPTH];
    logic [BYTES_W-1:0] rd_bytes_reg;
    logic [TIME_W-1:0]  rd_time_reg;

    // Write port; byte count and stamp written separately for merges
    always_ff @(posedge clk)
    begin
        if (ctl.wr_bytes)
        begin
            bytes_mem[wr_addr] <= wr_bytes_data;
        end
        if (ctl.wr_time)
        begin
            time_mem[wr_addr] <= wr_time_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_bytes_reg <= bytes_mem[rd_addr];
            rd_time_reg  <= time_mem[rd_addr];
        end
    end

    assign rd_bytes = rd_bytes_reg;
    assign rd_time  = rd_time_reg;

endmodule

/* rtl/swrm_div.sv */
module swrm_div
    import swrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [WIN_W-1:0]      divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  run_reg,  run_next;
    logic                  done_reg, done_next;
    logic [ITER_W-1:0]     cnt_reg,  cnt_next;
    logic [DIVIDEND_W-1:0] q_reg,    q_next;
    logic [WIN_W-1:0]      rem_reg,  rem_next;
    logic [WIN_W-1:0]      dvs_reg,  dvs_next;
    logic [WIN_W:0]        rem_sh;
    logic [WIN_W:0]        trial;
    logic                  fits;

    // One restoring step: shift in next dividend bit, try subtract
    assign rem_sh = {rem_reg, q_reg[DIVIDEND_W-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? trial[WIN_W-1:0] : rem_sh[WIN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ITER_W'(DIVIDEND_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/sliding_window_rate_meter.sv */
// Sliding-window rate meter. Pulse start while busy is low to hand in one item.
// A data item (operation 0) stores its byte count and stamp and adds to the window
// sum; when all FIFO_DEPTH entries are held, its bytes are instead merged into the
// newest entry, which keeps its stamp. An update item (operation 1) drops expired
// entries at one per cycle from the entry memory's read port, then runs a bit-serial
// divider for sum*1000/window_ms; with a zero sum or zero window the divider is
// skipped. The result appears on rate_bytes_per_sec, window_bytes and
// entries_held for one cycle with done high and must be captured then: there is no
// way to hold it. busy stays high from the cycle after start until the item is
// finished, which for an update is when the result is shown. Write window_ms through
// cfg_valid/cfg_data only while busy is low; it resets to 5000.
module sliding_window_rate_meter
    import swrm_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [BYTES_W-1:0] byte_count,
    input  logic [TIME_W-1:0]  time_ms,
    output logic               done,
    output logic [SUM_W-1:0]   rate_bytes_per_sec,
    output logic [SUM_W-1:0]   window_bytes,
    output logic [HELD_W-1:0]  entries_held,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIN_W-1:0]   cfg_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    state_t state_reg, state_next;

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [WIN_W-1:0]   window_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               done_reg, done_next;
    logic [SUM_W-1:0]   rate_reg, rate_next;
    logic [SUM_W-1:0]   wbytes_reg;
    logic [HELD_W-1:0]  held_reg;

    fifo_ctl_t          fifo_ctl;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [BYTES_W-1:0] wr_bytes_data;
    logic [BYTES_W-1:0] rd_bytes;
    logic [TIME_W-1:0]  rd_time;

    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVIDEND_W-1:0] quotient;

    logic               accept;
    logic               full;
    logic [AW-1:0]      newest;
    logic [AW-1:0]      head_inc;
    logic [SUM_W:0]     sum_add;
    logic [BYTES_W:0]   merge_sum;
    logic [TIME_W:0]    age;
    logic               stale;
    logic [SUM_W-1:0]   sum_sub;
    logic               rate_trivial;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;

    // Slot arithmetic with wrap at FIFO_DEPTH
    assign full     = (count_reg == CW'(FIFO_DEPTH));
    assign newest   = (tail_reg == '0) ? AW'(FIFO_DEPTH - 1) : tail_reg - 1'b1;
    assign head_inc = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Saturating adds for the sum and a merged entry
    assign sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(bytes_reg);
    assign merge_sum = {1'b0, rd_bytes} + {1'b0, bytes_reg};
    assign wr_bytes_data = (state_reg == ST_MERGE)
                           ? (merge_sum[BYTES_W] ? BYTES_MAX : merge_sum[BYTES_W-1:0])
                           : bytes_reg;

    // Expiry test on the head entry: stamped in the future, or too old
    assign age   = {1'b0, time_reg} - {1'b0, rd_time};
    assign stale = age[TIME_W] || (age[TIME_W-1:0] > TIME_W'(window_reg));
    assign sum_sub = (sum_reg >= SUM_W'(rd_bytes)) ? sum_reg - SUM_W'(rd_bytes) : '0;

    // sum * 1000 as (sum << 10) - (sum << 4) - (sum << 3)
    assign div_dividend = (DIVIDEND_W'(sum_reg) << 10)
                        - (DIVIDEND_W'(sum_reg) << 4)
                        - (DIVIDEND_W'(sum_reg) << 3);
    assign rate_trivial = (sum_reg == '0) || (window_reg == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (operation == OP_UPDATE) ? ST_EXP_RD : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                state_next = full ? ST_MERGE : ST_IDLE;
            end
            ST_MERGE:
            begin
                state_next = ST_IDLE;
            end
            ST_EXP_RD:
            begin
                state_next = (count_reg == '0) ? ST_RATE : ST_EXP_CHK;
            end
            ST_EXP_CHK:
            begin
                if (!stale || count_reg == CW'(1))
                begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                state_next = rate_trivial ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs to the entry store and divider
    always_comb
    begin
        fifo_ctl  = '0;
        wr_addr   = tail_reg;
        rd_addr   = head_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_PUSH:
            begin
                if (full)
                begin
                    fifo_ctl.rd_en = 1'b1;
                    rd_addr        = newest;
                end
                else
                begin
                    fifo_ctl.wr_bytes = 1'b1;
                    fifo_ctl.wr_time  = 1'b1;
                end
            end
            ST_MERGE:
            begin
                fifo_ctl.wr_bytes = 1'b1;
                wr_addr           = newest;
            end
            ST_EXP_RD:
            begin
                fifo_ctl.rd_en = (count_reg != '0);
            end
            ST_EXP_CHK:
            begin
                // fetch the following entry while this one is dropped
                fifo_ctl.rd_en = stale && (count_reg != CW'(1));
                rd_addr        = head_inc;
            end
            ST_RATE:
            begin
                div_start = !rate_trivial;
            end
            default:
            begin
            end
        endcase
    end

    // Queue pointers, sum and result
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        done_next  = 1'b0;
        rate_next  = rate_reg;
        case (state_reg)
            ST_PUSH:
            begin
                sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                if (!full)
                begin
                    tail_next  = (tail_reg == AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            ST_EXP_CHK:
            begin
                if (stale)
                begin
                    sum_next   = sum_sub;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            ST_RATE:
            begin
                if (rate_trivial)
                begin
                    done_next = 1'b1;
                    rate_next = (sum_reg == '0) ? '0 : SUM_MAX;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    done_next = 1'b1;
                    rate_next = (|quotient[DIVIDEND_W-1:SUM_W])
                                ? SUM_MAX : quotient[SUM_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            window_reg <= WINDOW_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
        end
    end

    // Item capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg <= byte_count;
            time_reg  <= time_ms;
        end
        rate_reg <= rate_next;
        if (done_next)
        begin
            wbytes_reg <= sum_reg;
            held_reg   <= HELD_W'(count_reg);
        end
    end

    swrm_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk           (clk),
        .ctl           (fifo_ctl),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .wr_bytes_data (wr_bytes_data),
        .wr_time_data  (time_reg),
        .rd_bytes      (rd_bytes),
        .rd_time       (rd_time)
    );

    swrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (window_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign done               = done_reg;
    assign rate_bytes_per_sec = rate_reg;
    assign window_bytes       = wbytes_reg;
    assign entries_held       = held_reg;

endmodule

/* rtl/swrm_checker.sv */
module swrm_checker
    import swrm_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [SUM_W-1:0]   rate_bytes_per_sec,
    input logic [SUM_W-1:0]   window_bytes,
    input logic [HELD_W-1:0]  entries_held
);

    // An accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    // Result beat only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A result needs a new update from idle, so result beats never touch
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beats in consecutive cycles");

    // An empty window reports zero rate
    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (done && window_bytes == '0) |-> (rate_bytes_per_sec == '0))
        else $error("nonzero rate with empty window");

    // Occupancy never exceeds the entry store
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(entries_held) <= 32'(FIFO_DEPTH)))
        else $error("entries_held beyond depth");

endmodule

bind sliding_window_rate_meter swrm_checker #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_swrm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .rate_bytes_per_sec (rate_bytes_per_sec),
    .window_bytes       (window_bytes),
    .entries_held       (entries_held)
);
